[rtl/core/binary_max_heap_priority_queue_unit_assert.svh]
// Assertion macros for the heap priority queue, clocked on clk_i, disabled in reset.
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Check that a condition holds at every edge.
`define BMHPQ_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next cycle.
`define BMHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Check that a condition implies another in the same cycle.
`define BMHPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/bmhpq_pkg.sv]
// Shared types and constants of the heap priority queue.
package bmhpq_pkg;

  localparam int unsigned DefCapacity = 1024;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned SlotW       = 10;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned EntryCountW = 11;

  typedef enum logic [1:0] {
    OpInsert   = 2'd0,
    OpExtract  = 2'd1,
    OpIncrease = 2'd2,
    OpNone     = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 3'd0,
    StEmpty   = 3'd1,
    StFull    = 3'd2,
    StSmaller = 3'd3,
    StIndex   = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [KeyW-1:0] extracted_key;
    status_e                status;
    logic signed [KeyW-1:0] top_key;
    logic [EntryCountW-1:0] entry_count;
  } res_t;

endpackage

[rtl/core/bmhpq_ram.sv]
// Heap key store: one write port, two registered read ports.
module bmhpq_ram import bmhpq_pkg::*; #(
  parameter int unsigned Depth = DefCapacity,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic signed [KeyW-1:0] wdata_i,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_a_i,
  input  logic [AddrW-1:0]       raddr_b_i,
  output logic signed [KeyW-1:0] rdata_a_o,
  output logic signed [KeyW-1:0] rdata_b_o
);

  logic signed [KeyW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

[rtl/core/bmhpq_core.sv]
// Sift sequencer with a shared signed key comparator and the heap store.
module bmhpq_core import bmhpq_pkg::*; #(
  parameter int unsigned Capacity = DefCapacity
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  op_e                    opcode_i,
  input  logic signed [KeyW-1:0] key_value_i,
  input  logic [SlotW-1:0]       slot_index_i,
  output logic                   busy_o,
  output logic                   done_o,
  output res_t                   res_o
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);

  typedef enum logic [8:0] {
    SIdle = 9'b000000001,
    SUp   = 9'b000000010,
    SUpC  = 9'b000000100,
    SInc  = 9'b000001000,
    SLast = 9'b000010000,
    SDn   = 9'b000100000,
    SDnL  = 9'b001000000,
    SDnR  = 9'b010000000,
    SDone = 9'b100000000
  } state_e;

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic signed [KeyW-1:0] best_key_q, best_key_d;
  logic                   best_lc_q, best_lc_d;
  logic signed [KeyW-1:0] taken_q, taken_d;
  logic signed [KeyW-1:0] root_q;
  status_e                status_q, status_d;

  logic                   we;
  logic [AW-1:0]          waddr;
  logic signed [KeyW-1:0] wdata;
  logic                   re;
  logic [AW-1:0]          raddr_a, raddr_b;
  logic signed [KeyW-1:0] rdata_a, rdata_b;

  logic signed [KeyW-1:0] cmp_a, cmp_b;
  logic                   cmp_gt;

  logic [AW-1:0]          parent;
  logic [CW:0]            lc, rc;
  logic                   lc_in, rc_in;
  logic                   rc_take;

  bmhpq_ram #(
    .Depth (Capacity),
    .AddrW (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (re),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign parent  = (pos_q - AW'(1)) >> 1;
  assign lc      = (CW+1)'({pos_q, 1'b1});
  assign rc      = lc + (CW+1)'(1);
  assign lc_in   = lc < (CW+1)'(count_q);
  assign rc_in   = rc < (CW+1)'(count_q);
  assign cmp_gt  = cmp_a > cmp_b;
  assign rc_take = rc_in && cmp_gt;

  always_comb begin
    cmp_a = rdata_a;
    cmp_b = key_q;
    unique case (state_q)
      SUpC: begin
        cmp_a = key_q;
        cmp_b = rdata_a;
      end
      SDnR: begin
        cmp_a = rdata_b;
        cmp_b = best_key_q;
      end
      default: begin
        cmp_a = rdata_a;
        cmp_b = key_q;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pos_d      = pos_q;
    key_d      = key_q;
    best_key_d = best_key_q;
    best_lc_d  = best_lc_q;
    taken_d    = taken_q;
    status_d   = status_q;
    we         = 1'b0;
    waddr      = pos_q;
    wdata      = key_q;
    re         = 1'b0;
    raddr_a    = lc[AW-1:0];
    raddr_b    = rc_in ? rc[AW-1:0] : lc[AW-1:0];
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          taken_d  = '0;
          status_d = StOk;
          key_d    = key_value_i;
          state_d  = SDone;
          unique case (opcode_i)
            OpInsert: begin
              if (count_q == CW'(Capacity)) begin
                status_d = StFull;
              end else begin
                pos_d   = count_q[AW-1:0];
                count_d = count_q + CW'(1);
                state_d = SUp;
              end
            end
            OpExtract: begin
              if (count_q == '0) begin
                status_d = StEmpty;
              end else begin
                taken_d = root_q;
                count_d = count_q - CW'(1);
                re      = 1'b1;
                raddr_a = count_d[AW-1:0];
                state_d = SLast;
              end
            end
            OpIncrease: begin
              if (32'(slot_index_i) >= 32'(count_q)) begin
                status_d = StIndex;
              end else begin
                pos_d   = AW'(slot_index_i);
                re      = 1'b1;
                raddr_a = AW'(slot_index_i);
                state_d = SInc;
              end
            end
            default: state_d = SDone;
          endcase
        end
      end
      SUp: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = SDone;
        end else begin
          re      = 1'b1;
          raddr_a = parent;
          state_d = SUpC;
        end
      end
      SUpC: begin
        we = 1'b1;
        if (cmp_gt) begin
          wdata   = rdata_a;
          pos_d   = parent;
          state_d = SUp;
        end else begin
          state_d = SDone;
        end
      end
      SInc: begin
        if (cmp_gt) begin
          status_d = StSmaller;
          state_d  = SDone;
        end else begin
          state_d = SUp;
        end
      end
      SLast: begin
        key_d = rdata_a;
        pos_d = '0;
        state_d = (count_q == '0) ? SDone : SDn;
      end
      SDn: begin
        if (!lc_in) begin
          we      = 1'b1;
          state_d = SDone;
        end else begin
          re      = 1'b1;
          state_d = SDnL;
        end
      end
      SDnL: begin
        best_lc_d  = cmp_gt;
        best_key_d = cmp_gt ? rdata_a : key_q;
        state_d    = SDnR;
      end
      SDnR: begin
        we = 1'b1;
        if (rc_take) begin
          wdata   = rdata_b;
          pos_d   = rc[AW-1:0];
          state_d = SDn;
        end else if (best_lc_q) begin
          wdata   = best_key_q;
          pos_d   = lc[AW-1:0];
          state_d = SDn;
        end else begin
          state_d = SDone;
        end
      end
      SDone: begin
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    key_q      <= key_d;
    best_key_q <= best_key_d;
    best_lc_q  <= best_lc_d;
    taken_q    <= taken_d;
    status_q   <= status_d;
    if (we && waddr == '0) begin
      root_q <= wdata;
    end
  end

  assign busy_o = state_q != SIdle;
  assign done_o = state_q == SDone;

  always_comb begin
    res_o.extracted_key = taken_q;
    res_o.status        = status_q;
    res_o.top_key       = (count_q != '0) ? root_q : '0;
    res_o.entry_count   = EntryCountW'(count_q);
  end

endmodule

[rtl/core/binary_max_heap_priority_queue_unit.sv]
// Max-priority queue of signed keys in an array binary heap, with insert, extract and increase.
// Each transfer runs alone through a sequencer that walks the heap one level at a time over a
// single store with one write port and two registered read ports. A full heap, an empty extract,
// a bad index and an unused opcode go straight to the result register; a smaller increase key
// stops after reading its slot, and an extract that empties the queue after reading the last entry.
// Insert climbs one level per parent read and compare; increase-key reads its slot first and
// then climbs as insert does; extract-max moves the last entry to the root and sinks it one
// level per read of both children and two compares, at most nine levels at the default 1024
// entries. The store needs no clearing after reset. A result waits in an output register; the
// next input transfer is taken once the sequencer is idle and that register is free or being
// drained.
module binary_max_heap_priority_queue_unit import bmhpq_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic signed [KeyW-1:0]        key_value_i,
  input  logic [SlotW-1:0]              slot_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [KeyW-1:0]        extracted_key_o,
  output logic [StatusW-1:0]            status_o,
  output logic signed [KeyW-1:0]        top_key_o,
  output logic [EntryCountW-1:0]        entry_count_o
);

  logic core_busy;
  logic core_done;
  logic start;
  res_t core_res;
  res_t res_q;
  logic out_valid_q, out_valid_d;

  assign in_stall_o = core_busy || (out_valid_q && out_stall_i);
  assign start      = in_valid_i && !in_stall_o;

  bmhpq_core #(
    .Capacity (CAPACITY)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .opcode_i     (op_e'(opcode_i)),
    .key_value_i  (key_value_i),
    .slot_index_i (slot_index_i),
    .busy_o       (core_busy),
    .done_o       (core_done),
    .res_o        (core_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (core_done) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign extracted_key_o = res_q.extracted_key;
  assign status_o        = res_q.status;
  assign top_key_o       = res_q.top_key;
  assign entry_count_o   = res_q.entry_count;

`include "binary_max_heap_priority_queue_unit_assert.svh"

  `BMHPQ_ASSERT_IMPL(a_done_free, core_done, !out_valid_q, "result overwrites pending result")
  `BMHPQ_ASSERT_NEXT(a_start_busy, start, core_busy, "sequencer idle after transfer")
  `BMHPQ_ASSERT_IMPL(a_err_zero, out_valid_o && status_o != StOk, extracted_key_o == '0,
                     "error result carries extracted key")

endmodule
